>>> rtl/rlpg_pkg.sv
// Shared types and constants for the raster line pixel generator.
`timescale 1ns / 1ps
`default_nettype none
package rlpg_pkg;

  localparam int unsigned WIDTH_BITS = 13;
  localparam int unsigned BPP_BITS   = 3;
  localparam int unsigned COLOR_BITS = 24;
  localparam int unsigned ADDR_BITS  = 26;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = WIDTH_BITS'(640);
  localparam logic [WIDTH_BITS-1:0] HEIGHT_RESET = WIDTH_BITS'(480);
  localparam logic [BPP_BITS-1:0]   BPP_RESET    = BPP_BITS'(3);

  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BYTES_PER_PIXEL = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;     // latch a new line
    logic advance;  // one Bresenham step
    logic calc;     // on-screen test and pixel index
    logic emit;     // scale to bytes and fill the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic line_active;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/rlpg_datapath.sv
// Datapath: line state, Bresenham step, address arithmetic and output register.
`timescale 1ns / 1ps
`default_nettype none
module rlpg_datapath #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  rlpg_pkg::dp_cmd_t                cmd_i,
  output rlpg_pkg::dp_status_t             status_o,
  input  wire                              cfg_we_i,
  input  wire [rlpg_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire [rlpg_pkg::WIDTH_BITS-1:0]   cfg_wdata_i,
  input  wire signed [COORD_BITS-1:0]      x_start_i,
  input  wire signed [COORD_BITS-1:0]      y_start_i,
  input  wire signed [COORD_BITS-1:0]      x_end_i,
  input  wire signed [COORD_BITS-1:0]      y_end_i,
  input  wire [rlpg_pkg::COLOR_BITS-1:0]   pen_color_i,
  output logic signed [COORD_BITS-1:0]     pixel_x_o,
  output logic signed [COORD_BITS-1:0]     pixel_y_o,
  output logic [rlpg_pkg::COLOR_BITS-1:0]  pixel_color_o,
  output logic [rlpg_pkg::ADDR_BITS-1:0]   byte_address_o,
  output logic                             on_screen_o,
  output logic                             last_pixel_o
);
  import rlpg_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned CMP_W = (C > WIDTH_BITS) ? C : WIDTH_BITS;

  logic [WIDTH_BITS-1:0] width_q, height_q;
  logic [BPP_BITS-1:0]   bpp_q;

  logic                  active_q, active_d;
  logic [C-1:0]          x_q, x_d, y_q, y_d;
  logic [C:0]            err_q, err_d;
  logic [C-1:0]          adx_q, adx_d, ady_q, ady_d;
  logic [3:0]            signs_q, signs_d;
  logic                  xmaj_q, xmaj_d;
  logic [C-1:0]          left_q, left_d;
  logic [COLOR_BITS-1:0] color_q;
  logic                  last_q, last_d;

  logic [ADDR_BITS-1:0]  idx_q;
  logic                  on_q;

  // load arithmetic
  logic signed [C:0] dx, dy;
  logic [C:0]        dx_mag, dy_mag;
  logic [C-1:0]      major_ld;

  // step arithmetic
  logic [C-1:0] major, minor, sx, sy;
  logic [C:0]   err_sum;
  logic         minor_step;

  // address arithmetic
  logic [CMP_W-1:0] x_ext, y_ext, w_ext, h_ext;
  logic             on_d;

  assign dx     = {x_end_i[C-1], x_end_i} - {x_start_i[C-1], x_start_i};
  assign dy     = {y_end_i[C-1], y_end_i} - {y_start_i[C-1], y_start_i};
  assign dx_mag = dx[C] ? (~dx + 1'b1) : dx;
  assign dy_mag = dy[C] ? (~dy + 1'b1) : dy;

  assign major   = xmaj_q ? adx_q : ady_q;
  assign minor   = xmaj_q ? ady_q : adx_q;
  assign err_sum = err_q + {1'b0, minor};
  assign minor_step = (err_sum >= {1'b0, major});
  assign sx = signs_q[0] ? C'(1) : (signs_q[1] ? '1 : '0);
  assign sy = signs_q[2] ? C'(1) : (signs_q[3] ? '1 : '0);

  always_comb begin
    active_d = active_q;
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    adx_d    = adx_q;
    ady_d    = ady_q;
    signs_d  = signs_q;
    xmaj_d   = xmaj_q;
    left_d   = left_q;
    last_d   = last_q;
    major_ld = '0;
    if (cmd_i.load) begin
      adx_d    = dx_mag[C-1:0];
      ady_d    = dy_mag[C-1:0];
      signs_d  = {dy[C], (!dy[C] && (dy != '0)), dx[C], (!dx[C] && (dx != '0))};
      xmaj_d   = (dx_mag[C-1:0] >= dy_mag[C-1:0]);
      major_ld = xmaj_d ? dx_mag[C-1:0] : dy_mag[C-1:0];
      err_d    = {2'b00, major_ld[C-1:1]};
      left_d   = major_ld;
      x_d      = x_start_i;
      y_d      = y_start_i;
      active_d = (major_ld != '0);
    end else if (cmd_i.advance) begin
      err_d = minor_step ? (err_sum - {1'b0, major}) : err_sum;
      if (xmaj_q || minor_step) begin
        x_d = x_q + sx;
      end
      if (!xmaj_q || minor_step) begin
        y_d = y_q + sy;
      end
      left_d   = left_q - 1'b1;
      last_d   = (left_q == C'(1));
      active_d = !last_d;
    end
  end

  assign x_ext = CMP_W'(x_q);
  assign y_ext = CMP_W'(y_q);
  assign w_ext = CMP_W'(width_q);
  assign h_ext = CMP_W'(height_q);
  assign on_d  = !x_q[C-1] && !y_q[C-1] && (x_ext < w_ext) && (y_ext < h_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      bpp_q    <= BPP_RESET;
      active_q <= 1'b0;
      x_q      <= '0;
      y_q      <= '0;
      err_q    <= '0;
      adx_q    <= '0;
      ady_q    <= '0;
      signs_q  <= '0;
      xmaj_q   <= 1'b0;
      left_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:     width_q  <= cfg_wdata_i;
          CFG_FRAME_HEIGHT:    height_q <= cfg_wdata_i;
          CFG_BYTES_PER_PIXEL: bpp_q    <= cfg_wdata_i[BPP_BITS-1:0];
          default:             ;
        endcase
      end
      active_q <= active_d;
      x_q      <= x_d;
      y_q      <= y_d;
      err_q    <= err_d;
      adx_q    <= adx_d;
      ady_q    <= ady_d;
      signs_q  <= signs_d;
      xmaj_q   <= xmaj_d;
      left_q   <= left_d;
      last_q   <= last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      color_q <= pen_color_i;
    end
    if (cmd_i.calc) begin
      on_q  <= on_d;
      idx_q <= ADDR_BITS'(x_ext) + (ADDR_BITS'(width_q) * ADDR_BITS'(y_q));
    end
    if (cmd_i.emit) begin
      pixel_x_o      <= x_q;
      pixel_y_o      <= y_q;
      pixel_color_o  <= color_q;
      byte_address_o <= on_q ? ADDR_BITS'(idx_q * bpp_q) : '0;
      on_screen_o    <= on_q;
      last_pixel_o   <= last_q;
    end
  end

  assign status_o.line_active = active_q;

  a_err_below_major: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (err_q < {1'b0, major}))
    else $error("error term reached the major delta");

  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (left_q != '0))
    else $error("active line with no pixels left");

endmodule
`default_nettype wire

>>> rtl/rlpg_controller.sv
// Controller: sequences load, step, address and output for each request.
`timescale 1ns / 1ps
`default_nettype none
module rlpg_controller (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire                   cmd_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  input  rlpg_pkg::dp_status_t  status_i,
  output rlpg_pkg::dp_cmd_t     cmd_o
);
  import rlpg_pkg::*;

  typedef enum logic [1:0] {StIdle, StCalc, StEmit} state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_take, out_free;

  assign in_ready_o = (state_q == StIdle);
  assign in_take    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        if (in_take) begin
          if (cmd_i == CMD_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (status_i.line_active) begin
            cmd_o.advance = 1'b1;
            state_d       = StCalc;
          end
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_calc_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCalc) |=> (state_q == StEmit))
    else $error("address stage not followed by emit");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> out_free)
    else $error("output register overwritten");

  a_step_needs_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.advance |-> status_i.line_active)
    else $error("step with no active line");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("emitted pixel not presented");

endmodule
`default_nettype wire

>>> rtl/raster_line_pixel_generator.sv
// Top level of the raster line pixel generator.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | cmd, endpoints, pen colour
//  out     | output    | out_valid_o/out_ready_i| pixel x/y, colour, address, flags
//  cfg     | input     | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// A load request latches a new line; a step request on an active line passes through
// the step, the pixel index multiply and the byte scaling into the output register.
// A step request with no active line is taken and gives nothing.
// Reset clears the line state and sets the frame registers to 640x480, 3 bytes.
// A full output register stalls the final stage until the pixel is taken.
`timescale 1ns / 1ps
`default_nettype none
module raster_line_pixel_generator #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [rlpg_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire [rlpg_pkg::WIDTH_BITS-1:0]   cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              cmd_i,
  input  wire signed [COORD_BITS-1:0]      x_start_i,
  input  wire signed [COORD_BITS-1:0]      y_start_i,
  input  wire signed [COORD_BITS-1:0]      x_end_i,
  input  wire signed [COORD_BITS-1:0]      y_end_i,
  input  wire [rlpg_pkg::COLOR_BITS-1:0]   pen_color_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic signed [COORD_BITS-1:0]     pixel_x_o,
  output logic signed [COORD_BITS-1:0]     pixel_y_o,
  output logic [rlpg_pkg::COLOR_BITS-1:0]  pixel_color_o,
  output logic [rlpg_pkg::ADDR_BITS-1:0]   byte_address_o,
  output logic                             on_screen_o,
  output logic                             last_pixel_o
);
  import rlpg_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  rlpg_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  rlpg_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .x_start_i      (x_start_i),
    .y_start_i      (y_start_i),
    .x_end_i        (x_end_i),
    .y_end_i        (y_end_i),
    .pen_color_i    (pen_color_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_color_o  (pixel_color_o),
    .byte_address_o (byte_address_o),
    .on_screen_o    (on_screen_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule
`default_nettype wire

>>> tb/sv/raster_line_pixel_generator_checker.sv
// Checker for the raster line pixel generator: tracks each line and compares every pixel.
`timescale 1ns / 1ps
module raster_line_pixel_generator_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [rlpg_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire [rlpg_pkg::WIDTH_BITS-1:0]   cfg_wdata_i,
  input  wire                              in_valid_i,
  input  wire                              in_ready_i,
  input  wire                              cmd_i,
  input  wire signed [COORD_BITS-1:0]      x_start_i,
  input  wire signed [COORD_BITS-1:0]      y_start_i,
  input  wire signed [COORD_BITS-1:0]      x_end_i,
  input  wire signed [COORD_BITS-1:0]      y_end_i,
  input  wire [rlpg_pkg::COLOR_BITS-1:0]   pen_color_i,
  input  wire                              out_valid_i,
  input  wire                              out_ready_i,
  input  wire signed [COORD_BITS-1:0]      pixel_x_i,
  input  wire signed [COORD_BITS-1:0]      pixel_y_i,
  input  wire [rlpg_pkg::COLOR_BITS-1:0]   pixel_color_i,
  input  wire [rlpg_pkg::ADDR_BITS-1:0]    byte_address_i,
  input  wire                              on_screen_i,
  input  wire                              last_pixel_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import rlpg_pkg::*;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0]        color;
    logic [ADDR_BITS-1:0]         addr;
    logic                         is_on;
    logic                         is_last;
  } pixel_t;

  pixel_t expected_pixels[$];
  int     fails = 0;

  logic [WIDTH_BITS-1:0]        frame_w;
  logic [WIDTH_BITS-1:0]        frame_h;
  logic [BPP_BITS-1:0]          bpp;
  logic                         line_live;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic [COORD_BITS+1:0]        err;
  logic [COORD_BITS-1:0]        run_x;
  logic [COORD_BITS-1:0]        run_y;
  int                           dir_x;
  int                           dir_y;
  logic                         x_leads;
  logic [COORD_BITS-1:0]        remaining;
  logic [COLOR_BITS-1:0]        ink;

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS-1:0]      major;
    longint                     idx;
    pixel_t                     want;
    pixel_t                     got;
    if (!rst_ni) begin
      frame_w   = WIDTH_RESET;
      frame_h   = HEIGHT_RESET;
      bpp       = BPP_RESET;
      line_live = 1'b0;
      cur_x     = '0;
      cur_y     = '0;
      err       = '0;
      run_x     = '0;
      run_y     = '0;
      dir_x     = 0;
      dir_y     = 0;
      x_leads   = 1'b0;
      remaining = '0;
      ink       = '0;
      expected_pixels.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:     frame_w = cfg_wdata_i;
          CFG_FRAME_HEIGHT:    frame_h = cfg_wdata_i;
          CFG_BYTES_PER_PIXEL: bpp = cfg_wdata_i[BPP_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        got = '{pixel_x_i, pixel_y_i, pixel_color_i, byte_address_i, on_screen_i,
                last_pixel_i};
        if (expected_pixels.size() == 0) begin
          if (fails < 10)
            $display("unexpected pixel x=%0d y=%0d colour=%h addr=%h on=%b last=%b",
                     got.x, got.y, got.color, got.addr, got.is_on, got.is_last);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
              got.addr !== want.addr || got.is_on !== want.is_on ||
              got.is_last !== want.is_last) begin
            if (fails < 10) begin
              $display("pixel mismatch: expected x=%0d y=%0d colour=%h addr=%h on=%b last=%b",
                       want.x, want.y, want.color, want.addr, want.is_on, want.is_last);
              $display("                actual   x=%0d y=%0d colour=%h addr=%h on=%b last=%b",
                       got.x, got.y, got.color, got.addr, got.is_on, got.is_last);
            end
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CMD_LOAD) begin
          dx = $signed({x_end_i[COORD_BITS-1], x_end_i}) -
               $signed({x_start_i[COORD_BITS-1], x_start_i});
          dy = $signed({y_end_i[COORD_BITS-1], y_end_i}) -
               $signed({y_start_i[COORD_BITS-1], y_start_i});
          dir_x     = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
          dir_y     = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
          run_x     = COORD_BITS'((dx < 0) ? -dx : dx);
          run_y     = COORD_BITS'((dy < 0) ? -dy : dy);
          x_leads   = run_x >= run_y;
          major     = x_leads ? run_x : run_y;
          err       = major >> 1;
          remaining = major;
          cur_x     = x_start_i;
          cur_y     = y_start_i;
          ink       = pen_color_i;
          line_live = major != 0;
        end else if (line_live) begin
          if (x_leads) begin
            err = err + run_y;
            if (err >= run_x) begin
              err   = err - run_x;
              cur_y = cur_y + dir_y;
            end
            cur_x = cur_x + dir_x;
          end else begin
            err = err + run_x;
            if (err >= run_y) begin
              err   = err - run_y;
              cur_x = cur_x + dir_x;
            end
            cur_y = cur_y + dir_y;
          end
          remaining    = remaining - 1'b1;
          want.x       = cur_x;
          want.y       = cur_y;
          want.color   = ink;
          want.is_last = remaining == 0;
          line_live    = !want.is_last;
          want.is_on   = int'(cur_x) >= 0 && int'(cur_y) >= 0 &&
                         int'(cur_x) < int'(frame_w) && int'(cur_y) < int'(frame_h);
          want.addr    = '0;
          if (want.is_on) begin
            idx       = longint'(cur_x) + longint'(frame_w) * longint'(cur_y);
            want.addr = ADDR_BITS'(idx * longint'(bpp));
          end
          expected_pixels.push_back(want);
        end
      end

      pending_o    <= expected_pixels.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> tb/sv/raster_line_pixel_generator_tb.sv
// Testbench top for the raster line pixel generator: stimulus, frame settings and verdict.
`timescale 1ns / 1ps
module raster_line_pixel_generator_tb;
  import rlpg_pkg::*;

  localparam int unsigned COORD_BITS = 12;
  localparam int          COORD_LIM  = 2 ** (COORD_BITS - 1);
  localparam int          ITEM_GOAL  = 1450;
  localparam int          PHASES     = 9;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [WIDTH_BITS-1:0]   cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic                    cmd_i       = CMD_LOAD;
  logic [COORD_BITS-1:0]   x_start_i   = '0;
  logic [COORD_BITS-1:0]   y_start_i   = '0;
  logic [COORD_BITS-1:0]   x_end_i     = '0;
  logic [COORD_BITS-1:0]   y_end_i     = '0;
  logic [COLOR_BITS-1:0]   pen_color_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [COORD_BITS-1:0]   pixel_x_o;
  logic [COORD_BITS-1:0]   pixel_y_o;
  logic [COLOR_BITS-1:0]   pixel_color_o;
  logic [ADDR_BITS-1:0]    byte_address_o;
  logic                    on_screen_o;
  logic                    last_pixel_o;
  logic                    calm        = 1'b0;
  int                      fail_count;
  int                      pending_pixels;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  raster_line_pixel_generator #(.COORD_BITS(COORD_BITS)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .cmd_i, .x_start_i, .y_start_i, .x_end_i, .y_end_i,
    .pen_color_i, .out_valid_o, .out_ready_i, .pixel_x_o, .pixel_y_o, .pixel_color_o,
    .byte_address_o, .on_screen_o, .last_pixel_o
  );

  raster_line_pixel_generator_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .x_start_i, .y_start_i,
    .x_end_i, .y_end_i, .pen_color_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pixel_x_i(pixel_x_o), .pixel_y_i(pixel_y_o),
    .pixel_color_i(pixel_color_o), .byte_address_i(byte_address_o),
    .on_screen_i(on_screen_o), .last_pixel_i(last_pixel_o),
    .fail_count_o(fail_count), .pending_o(pending_pixels)
  );

  always @(posedge clk_i) begin
    if (calm) out_ready_i <= 1'b1;
    else      out_ready_i <= $urandom_range(0, 99) >= 28;
  end

  function automatic int clamp_coord(int v);
    if (v > COORD_LIM - 1) return COORD_LIM - 1;
    if (v < -COORD_LIM)    return -COORD_LIM;
    return v;
  endfunction

  task automatic issue_request(input logic c, input logic [COORD_BITS-1:0] xs, ys, xe, ye,
                               input logic [COLOR_BITS-1:0] col);
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    x_start_i   <= xs;
    y_start_i   <= ys;
    x_end_i     <= xe;
    y_end_i     <= ye;
    pen_color_i <= col;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // load a line, then pull the given number of pixels with junk endpoint fields
  task automatic draw_line(input int xs, ys, xe, ye, input logic [COLOR_BITS-1:0] col,
                           input int steps);
    issue_request(CMD_LOAD, COORD_BITS'(xs), COORD_BITS'(ys), COORD_BITS'(xe),
                  COORD_BITS'(ye), col);
    repeat (steps) issue_request(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                                 COORD_BITS'($urandom), COORD_BITS'($urandom),
                                 COLOR_BITS'($urandom));
  endtask

  // hold requests until every pixel has come back and the pipeline is empty
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [WIDTH_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int                    sent;
    int                    goal;
    int                    r;
    int                    xs, ys, xe, ye, dx, dy, adx, ady, major, steps;
    int                    span_x, span_y;
    logic [WIDTH_BITS-1:0] w, h;
    logic [BPP_BITS-1:0]   b;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    draw_line(0, 0, 3, 1, 24'hFFFFFF, 3);
    issue_request(CMD_STEP, '0, '0, '0, '0, 24'h000000);
    draw_line(5, 5, 5, 5, 24'h000000, 1);
    draw_line(10, 10, 7, 13, 24'h123456, 3);
    draw_line(-COORD_LIM, -COORD_LIM, COORD_LIM - 1, COORD_LIM - 1, 24'hA5A5A5, 2);
    draw_line(COORD_LIM - 1, COORD_LIM - 1, -COORD_LIM, -COORD_LIM, 24'h5A5A5A, 1);
    draw_line(100, 479, 101, 475, 24'h00FF00, 4);
    draw_line(639, 0, 641, 0, 24'h0000FF, 2);
    drain();

    sent = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin w = 640;  h = 480;  b = 3; end
        1:       begin w = 1;    h = 1;    b = 1; end
        2:       begin w = 4096; h = 4096; b = 4; end
        3:       begin w = 0;    h = 480;  b = 3; end
        4:       begin w = 640;  h = 0;    b = 2; end
        5:       begin w = 320;  h = 240;  b = 0; end
        6:       begin w = 8191; h = 8191; b = 7; end
        7:       begin w = 4096; h = 2048; b = 5; end
        default: begin
          w = WIDTH_BITS'($urandom_range(1, 64));
          h = WIDTH_BITS'($urandom_range(1, 64));
          b = BPP_BITS'($urandom_range(1, 4));
        end
      endcase
      write_reg(CFG_FRAME_WIDTH, w);
      write_reg(CFG_FRAME_HEIGHT, h);
      write_reg(CFG_BYTES_PER_PIXEL, {(WIDTH_BITS - BPP_BITS)'($urandom), b});
      calm <= (phase == 2);
      span_x = (int'(w) > COORD_LIM - 1) ? COORD_LIM - 1 : int'(w);
      span_y = (int'(h) > COORD_LIM - 1) ? COORD_LIM - 1 : int'(h);
      goal   = (phase + 1) * ITEM_GOAL / PHASES;

      while (sent < goal) begin
        r = $urandom_range(0, 99);
        if (r < 96) begin
          if (r < 70) begin
            xs = clamp_coord(int'($urandom_range(0, span_x + 16)) - 8);
            ys = clamp_coord(int'($urandom_range(0, span_y + 16)) - 8);
          end else begin
            xs = int'($urandom_range(0, 2 * COORD_LIM - 1)) - COORD_LIM;
            ys = int'($urandom_range(0, 2 * COORD_LIM - 1)) - COORD_LIM;
          end
          dx = int'($urandom_range(0, 24)) - 12;
          dy = int'($urandom_range(0, 24)) - 12;
          if ($urandom_range(0, 9) == 0) dy = $urandom_range(0, 1) ? dx : -dx;
          xe = clamp_coord(xs + dx);
          ye = clamp_coord(ys + dy);
        end else begin
          xs = int'($urandom_range(0, 2 * COORD_LIM - 1)) - COORD_LIM;
          ys = int'($urandom_range(0, 2 * COORD_LIM - 1)) - COORD_LIM;
          xe = int'($urandom_range(0, 2 * COORD_LIM - 1)) - COORD_LIM;
          ye = int'($urandom_range(0, 2 * COORD_LIM - 1)) - COORD_LIM;
        end
        adx   = (xe > xs) ? xe - xs : xs - xe;
        ady   = (ye > ys) ? ye - ys : ys - ye;
        major = (adx >= ady) ? adx : ady;
        if (r >= 96) begin
          steps = (major < 30) ? major : $urandom_range(1, 30);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 80)      steps = major;
          else if (r < 90) steps = $urandom_range(0, major);
          else             steps = major + $urandom_range(1, 2);
        end
        draw_line(xs, ys, xe, ye, COLOR_BITS'($urandom), steps);
        sent += 1 + ((steps < major) ? steps : major);
        if ($urandom_range(0, 99) < 2) drain();
      end
      drain();
    end
    calm <= 1'b0;
    drain();

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else                 $display("CHECKS FAILED");
    $finish;
  end

endmodule
